// ===== hdl/sgsl_pkg.sv =====
package sgsl_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int ADDR_BITS    = 48;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic CFG_TOTAL_SIZE      = 1'b0;
  localparam logic CFG_SEGMENTS_IN_USE = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOS = 1'b1;

  typedef struct packed {
    logic                 func;
    logic [3:0]           entry_index;
    logic [31:0]          entry_length;
    logic [ADDR_BITS-1:0] entry_address;
    logic                 entry_address_valid;
    logic [31:0]          position;
    logic [31:0]          request_bytes;
  } in_req_t;

  typedef struct packed {
    logic                 status;
    logic [3:0]           first_segment;
    logic [4:0]           segment_count;
    logic [31:0]          byte_count;
    logic                 is_partial;
    logic [ADDR_BITS-1:0] part_address;
    logic                 part_address_valid;
    logic [31:0]          part_length;
  } out_req_t;

  // table load toward the cells
  typedef struct packed {
    logic                 we;
    logic [3:0]           idx;
    logic [31:0]          len;
    logic [ADDR_BITS-1:0] addr;
    logic                 av;
  } load_t;

  // walk record handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic                 mode;    // 0 locate start, 1 find end
    logic [3:0]           start;
    logic [4:0]           n;
    logic [31:0]          pos;
    logic [32:0]          endx;
    logic [32:0]          sum;
    logic [31:0]          lenacc;
    logic                 done;
    logic [3:0]           slot;
    logic [31:0]          elen;
    logic [ADDR_BITS-1:0] eaddr;
    logic                 eav;
  } walk_t;

endpackage

// ===== hdl/sgsl_cell.sv =====
module sgsl_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [3:0]     my_idx,
  input  sgsl_pkg::load_t ld,
  input  sgsl_pkg::walk_t rec_i,
  output sgsl_pkg::walk_t rec_o
);

  logic [31:0]                    len_r;
  logic [sgsl_pkg::ADDR_BITS-1:0] addr_r;
  logic                           av_r;
  logic                           vld_r;
  sgsl_pkg::walk_t                rec_nxt;
  sgsl_pkg::walk_t                rec_r;
  logic [32:0]                    ds;
  logic                           active;

  // hold this cell's table entry
  always_ff @(posedge clk) begin
    if (ld.we && ld.idx == my_idx) begin
      len_r  <= ld.len;
      addr_r <= ld.addr;
      av_r   <= ld.av;
    end
  end

  // step the walk record through this entry
  always_comb begin
    rec_nxt = rec_i;
    ds      = rec_i.sum + {1'b0, len_r};
    active  = ({1'b0, my_idx} >= {1'b0, rec_i.start}) && ({1'b0, my_idx} < rec_i.n) &&
              !rec_i.done;
    if (!rec_i.mode && my_idx == rec_i.start) begin
      rec_nxt.elen  = len_r;
      rec_nxt.eaddr = addr_r;
      rec_nxt.eav   = av_r;
    end
    if (active) begin
      if (!rec_i.mode) begin
        if (ds > {1'b0, rec_i.pos}) begin
          rec_nxt.done  = 1'b1;
          rec_nxt.slot  = my_idx;
          rec_nxt.elen  = len_r;
          rec_nxt.eaddr = addr_r;
          rec_nxt.eav   = av_r;
        end else begin
          rec_nxt.sum = ds;
        end
      end else begin
        if (ds >= rec_i.endx) begin
          rec_nxt.done = 1'b1;
          rec_nxt.slot = my_idx;
        end else begin
          rec_nxt.sum    = ds;
          rec_nxt.lenacc = rec_i.lenacc + len_r;
        end
      end
    end
  end

  // advance the record to the neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= rec_i.valid;
    end
    rec_r <= rec_nxt;
  end

  always_comb begin
    rec_o       = rec_r;
    rec_o.valid = vld_r;
  end

endmodule

// ===== hdl/scatter_gather_segment_locator.sv =====
// Scatter-gather segment locator. A load request (func 0) writes one table
// entry. A query request (func 1) runs a walk record down a row of sixteen
// cells, one cell per cycle, each holding one table entry. One pass down the
// row suffices when the position is inside a segment or the request runs to
// the end of the buffer; otherwise a second pass must find where the request
// ends. No walk runs when the position is out of space. One query is at work
// at a time; the result waits in an output register while the next request is
// taken.
module scatter_gather_segment_locator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sgsl_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sgsl_pkg::out_req_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [1:0] {IDLE, LOC, ENDP, RES} state_t;

  state_t             state_r;
  logic [31:0]        total_r;
  logic [4:0]         siu_r;
  logic [3:0]         ccur_r;
  logic [31:0]        cbase_r;
  logic [31:0]        req_r;
  sgsl_pkg::walk_t    launch_r;
  sgsl_pkg::out_req_t res_r;
  logic               out_valid_r;
  sgsl_pkg::out_req_t out_r;
  sgsl_pkg::load_t    ld;
  sgsl_pkg::walk_t    chain [sgsl_pkg::MAX_SEGMENTS+1];
  sgsl_pkg::walk_t    last;
  logic               in_acc;
  logic [4:0]         n_cl;
  logic [31:0]        off;
  logic [31:0]        plen;
  logic [32:0]        endx;

  assign in_stall  = (state_r != IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign n_cl      = (siu_r > 5'(sgsl_pkg::MAX_SEGMENTS)) ? 5'(sgsl_pkg::MAX_SEGMENTS) : siu_r;

  always_comb begin
    ld.we   = in_acc && in_data.func == sgsl_pkg::FUNC_LOAD;
    ld.idx  = in_data.entry_index;
    ld.len  = in_data.entry_length;
    ld.addr = in_data.entry_address;
    ld.av   = in_data.entry_address_valid;
  end

  // row of cells
  assign chain[0] = launch_r;
  for (genvar k = 0; k < sgsl_pkg::MAX_SEGMENTS; k++) begin : g_cell
    sgsl_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .my_idx(4'(k)),
      .ld    (ld),
      .rec_i (chain[k]),
      .rec_o (chain[k+1])
    );
  end
  assign last = chain[sgsl_pkg::MAX_SEGMENTS];

  // derive piece values from the record leaving the row
  always_comb begin
    off  = last.pos - last.sum[31:0];
    plen = (last.elen > off) ? last.elen - off : 32'd0;
    if (plen > req_r) plen = req_r;
    endx = {1'b0, last.pos} + {1'b0, req_r};
  end

  // sequence the query and hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= IDLE;
      total_r        <= '0;
      siu_r          <= '0;
      ccur_r         <= '0;
      cbase_r        <= '0;
      launch_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      launch_r.valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == sgsl_pkg::CFG_TOTAL_SIZE) total_r <= cfg_data;
        else siu_r <= cfg_data[4:0];
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        IDLE: begin
          if (in_acc && in_data.func == sgsl_pkg::FUNC_QUERY) begin
            req_r <= in_data.request_bytes;
            res_r <= '0;
            if (in_data.position >= total_r) begin
              res_r.status <= sgsl_pkg::STATUS_OOS;
              state_r      <= RES;
            end else begin
              launch_r       <= '0;
              launch_r.valid <= 1'b1;
              launch_r.n     <= n_cl;
              launch_r.pos   <= in_data.position;
              if (in_data.position < cbase_r) begin
                launch_r.start <= '0;
                launch_r.slot  <= '0;
                launch_r.sum   <= '0;
              end else begin
                launch_r.start <= ccur_r;
                launch_r.slot  <= ccur_r;
                launch_r.sum   <= {1'b0, cbase_r};
              end
              state_r <= LOC;
            end
          end
        end
        LOC: begin
          if (last.valid) begin
            ccur_r              <= last.slot;
            cbase_r             <= last.sum[31:0];
            res_r.first_segment <= last.slot;
            if (off != 32'd0) begin
              res_r.segment_count      <= 5'd1;
              res_r.byte_count         <= plen;
              res_r.is_partial         <= 1'b1;
              res_r.part_length        <= plen;
              res_r.part_address_valid <= last.eav;
              res_r.part_address       <= last.eav ?
                last.eaddr + sgsl_pkg::ADDR_BITS'(off) : '0;
              state_r <= RES;
            end else if (endx >= {1'b0, total_r}) begin
              res_r.segment_count <= (last.n > {1'b0, last.slot}) ?
                last.n - {1'b0, last.slot} : 5'd0;
              res_r.byte_count <= (endx > {1'b0, total_r}) ?
                total_r - last.pos : req_r;
              state_r <= RES;
            end else begin
              launch_r        <= last;
              launch_r.valid  <= 1'b1;
              launch_r.mode   <= 1'b1;
              launch_r.start  <= last.slot;
              launch_r.done   <= 1'b0;
              launch_r.endx   <= endx;
              launch_r.lenacc <= '0;
              state_r         <= ENDP;
            end
          end
        end
        ENDP: begin
          if (last.valid) begin
            if (last.slot == last.start) begin
              res_r.segment_count      <= 5'd1;
              res_r.byte_count         <= req_r;
              res_r.is_partial         <= 1'b1;
              res_r.part_length        <= req_r;
              res_r.part_address_valid <= last.eav;
              res_r.part_address       <= last.eav ? last.eaddr : '0;
            end else begin
              res_r.segment_count <= 5'(last.slot) - 5'(last.start);
              res_r.byte_count    <= last.lenacc;
            end
            state_r <= RES;
          end
        end
        RES: begin
          if (!out_valid_r || !out_stall) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  // a walk record leaves the row only while a walk is under way
  a_walk_state: assert property (@(posedge clk) disable iff (!rst_n)
    last.valid |-> (state_r == LOC || state_r == ENDP))
    else $error("walk record outside a walk");

  // out of space answers carry no segments
  a_oos_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == sgsl_pkg::STATUS_OOS) |->
      (out_r.segment_count == 5'd0 && !out_r.is_partial))
    else $error("out of space result with segments");

  // in the result state with a free output, the result moves to the output as the query returns to idle
  a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RES && (!out_valid_r || !out_stall)) |=> (out_valid_r && state_r == IDLE))
    else $error("result not moved to output");

endmodule
